// ===== rtl/core/ases_pkg.sv =====
// ----------------------------------------------------------------------------
// ases_pkg
// Shared types and constants of the add/subtract expression evaluator.
// ----------------------------------------------------------------------------
package ases_pkg;

  // width of the internal arithmetic, results wrap modulo 2^VALUE_WIDTH
  localparam int VALUE_WIDTH = 32;

  // depth of the token queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  localparam logic [3:0] TEN = 4'd10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ases_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               ok;
  } ases_out_t;

  typedef enum logic [1:0] {
    TK_OTHER,
    TK_DIGIT,
    TK_PLUS,
    TK_MINUS
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic       last;
  } token_t;

  // valid/ready pair between two stages
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ===== rtl/core/ases_front.sv =====
// ----------------------------------------------------------------------------
// ases_front
// Accepts input bytes and classifies each into a token (digit, plus, minus,
// other) held in a one-entry output register.
// ----------------------------------------------------------------------------
module ases_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ases_pkg::ases_in_t in_data,
  output ases_pkg::token_t  tok_data,
  output logic              tok_valid,
  input  logic              tok_ready
);
  import ases_pkg::*;

  logic   valid_r;
  logic   valid_nxt;
  token_t tok_r;
  token_t tok_nxt;

  always_comb begin
    tok_nxt.last  = in_data.last;
    tok_nxt.digit = 4'(in_data.ch - CH_ZERO);
    if ((in_data.ch >= CH_ZERO) && (in_data.ch <= CH_NINE)) begin
      tok_nxt.kind = TK_DIGIT;
    end else if (in_data.ch == CH_PLUS) begin
      tok_nxt.kind = TK_PLUS;
    end else if (in_data.ch == CH_MINUS) begin
      tok_nxt.kind = TK_MINUS;
    end else begin
      tok_nxt.kind = TK_OTHER;
    end
  end

  assign in_ready  = !valid_r || tok_ready;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !tok_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_valid = valid_r;
  assign tok_data  = tok_r;

endmodule

// ===== rtl/core/ases_queue.sv =====
// ----------------------------------------------------------------------------
// ases_queue
// Small register queue of tokens that decouples the front from the back.
// ----------------------------------------------------------------------------
module ases_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  ases_pkg::token_t wr_data,
  input  logic             wr_valid,
  output logic             wr_ready,
  output ases_pkg::token_t rd_data,
  output ases_pkg::hs_t    rd_hs_o,
  input  logic             rd_ready
);
  import ases_pkg::*;

  token_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW:0]   wr_ptr_r;
  logic [QUEUE_AW:0]   wr_ptr_nxt;
  logic [QUEUE_AW:0]   rd_ptr_r;
  logic [QUEUE_AW:0]   rd_ptr_nxt;
  logic                full;
  logic                empty;
  logic                do_wr;
  logic                do_rd;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[QUEUE_AW] != rd_ptr_r[QUEUE_AW]) &&
                 (wr_ptr_r[QUEUE_AW-1:0] == rd_ptr_r[QUEUE_AW-1:0]);

  assign wr_ready = !full;
  assign do_wr    = wr_valid && !full;
  assign do_rd    = rd_ready && !empty;

  assign wr_ptr_nxt = wr_ptr_r + (QUEUE_AW+1)'(do_wr);
  assign rd_ptr_nxt = rd_ptr_r + (QUEUE_AW+1)'(do_rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
    if (do_wr) begin
      mem_r[wr_ptr_r[QUEUE_AW-1:0]] <= wr_data;
    end
  end

  assign rd_data       = mem_r[rd_ptr_r[QUEUE_AW-1:0]];
  assign rd_hs_o.valid = !empty;
  assign rd_hs_o.ready = rd_ready;

endmodule

// ===== rtl/core/ases_back.sv =====
// ----------------------------------------------------------------------------
// ases_back
// Evaluates the token stream: builds numbers, keeps the running sum and the
// parse state, and registers one result per expression.
// ----------------------------------------------------------------------------
module ases_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ases_pkg::token_t    tok_data,
  input  ases_pkg::hs_t       tok_hs,
  output logic                tok_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ases_pkg::ases_out_t out_data
);
  import ases_pkg::*;

  logic [VALUE_WIDTH-1:0] sum_r, sum_nxt;
  logic [VALUE_WIDTH-1:0] cur_r, cur_nxt;
  logic                   ind_r, ind_nxt;
  logic                   aft_r, aft_nxt;
  logic                   pm_r, pm_nxt;
  logic                   err_r, err_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ases_out_t              out_r, out_nxt;

  logic [VALUE_WIDTH-1:0] cur_dig;
  logic [VALUE_WIDTH-1:0] sum_s;
  logic [VALUE_WIDTH-1:0] cur_s;
  logic                   ind_s, aft_s, pm_s, err_s;
  logic [VALUE_WIDTH-1:0] sum_fin;
  logic                   ok;
  logic                   take;

  // a non-final token never produces a result, so only a final one waits
  assign tok_ready = !tok_data.last || !out_valid_r || out_ready;
  assign take      = tok_hs.valid && tok_ready;

  // times ten as shift and add
  assign cur_dig = (cur_r << 3) + (cur_r << 1) + VALUE_WIDTH'(tok_data.digit);

  always_comb begin
    sum_s = sum_r;
    cur_s = cur_r;
    ind_s = ind_r;
    aft_s = aft_r;
    pm_s  = pm_r;
    err_s = err_r;
    if (tok_data.kind == TK_DIGIT) begin
      if (!ind_r) begin
        if (aft_r) begin
          err_s = 1'b1;
        end
        ind_s = 1'b1;
        cur_s = VALUE_WIDTH'(tok_data.digit);
      end else begin
        cur_s = cur_dig;
      end
    end else begin
      if (ind_r) begin
        sum_s = pm_r ? (sum_r - cur_r) : (sum_r + cur_r);
        cur_s = '0;
        ind_s = 1'b0;
        aft_s = 1'b1;
      end
      if ((tok_data.kind == TK_PLUS) || (tok_data.kind == TK_MINUS)) begin
        if (!aft_s) begin
          err_s = 1'b1;
        end
        pm_s  = (tok_data.kind == TK_MINUS);
        aft_s = 1'b0;
      end
    end
  end

  // number still open at the final byte is finished here
  always_comb begin
    sum_fin = sum_s;
    if (ind_s) begin
      sum_fin = pm_s ? (sum_s - cur_s) : (sum_s + cur_s);
    end
    ok = !err_s && (aft_s || ind_s);
    out_nxt.ok    = ok;
    out_nxt.value = ok ? 32'(signed'(sum_fin)) : '0;
  end

  always_comb begin
    sum_nxt       = sum_r;
    cur_nxt       = cur_r;
    ind_nxt       = ind_r;
    aft_nxt       = aft_r;
    pm_nxt        = pm_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (take) begin
      if (tok_data.last) begin
        sum_nxt       = '0;
        cur_nxt       = '0;
        ind_nxt       = 1'b0;
        aft_nxt       = 1'b0;
        pm_nxt        = 1'b0;
        err_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        sum_nxt = sum_s;
        cur_nxt = cur_s;
        ind_nxt = ind_s;
        aft_nxt = aft_s;
        pm_nxt  = pm_s;
        err_nxt = err_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cur_r       <= '0;
      ind_r       <= 1'b0;
      aft_r       <= 1'b0;
      pm_r        <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      cur_r       <= cur_nxt;
      ind_r       <= ind_nxt;
      aft_r       <= aft_nxt;
      pm_r        <= pm_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (take && tok_data.last) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/add_sub_expression_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// add_sub_expression_evaluator_top
// Streaming evaluator of '+'/'-' expressions over unsigned decimal numbers.
// ----------------------------------------------------------------------------
// The block takes one ASCII byte per cycle unless a waiting result backs up the queue:
// a front stage classifies each byte, a small token queue follows, and the
// back stage does one times-ten-and-add per byte plus the running sum update.
// A byte reaches the back via the front token register and the queue. On the
// byte marked last one transaction comes out with the 32-bit wrapped sum and
// ok; ok is 0 (and value 0) for empty input, a leading, doubled or trailing
// operator, or two numbers in a row. Bytes other than digits and operators
// are skipped but end a number. While a result waits on out_ready, bytes of
// the next expression keep flowing until the queue fills or a next last
// byte reaches the back.
module add_sub_expression_evaluator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ases_pkg::ases_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ases_pkg::ases_out_t out_data
);
  import ases_pkg::*;

  token_t f_tok;
  logic   f_valid;
  logic   f_ready;
  token_t q_tok;
  hs_t    q_hs;
  logic   b_ready;

  ases_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .tok_data (f_tok),
    .tok_valid(f_valid),
    .tok_ready(f_ready)
  );

  ases_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_data (f_tok),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .rd_data (q_tok),
    .rd_hs_o (q_hs),
    .rd_ready(b_ready)
  );

  ases_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_data (q_tok),
    .tok_hs   (q_hs),
    .tok_ready(b_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming add/subtract expression evaluator.
// A short table of hand-picked expressions runs first, then about 1200 random
// bytes, mostly well-formed expressions with random spacing plus broken ones
// and raw noise. Every accepted byte also goes through a local model of the
// parser; each result transaction is compared with the oldest expected sum.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ases_pkg::*;

  localparam int ITEMS_TOTAL = 1230;
  localparam int QUIET_TAIL  = 150;

  typedef struct {
    string              text;
    bit                 typed;
    logic signed [31:0] value;
    logic               ok;
  } expr_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  ases_in_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ases_out_t out_data;

  // local copy of the parser state
  logic [31:0] sum_acc;
  logic [31:0] num_acc;
  bit          in_run;
  bit          num_seen;
  bit          sub_next;
  bit          bad_syntax;

  ases_out_t sum_q[$];
  ases_out_t head_sum;
  ases_in_t  pend_bytes[$];
  int        mism_cnt = 0;
  int        sent_cnt = 0;
  bit        quiet = 1'b0;
  bit        tx_gappy = 1'b1;
  int        rx_hold = 0;
  int        rx_cycles = 0;
  bit        rx_calm = 1'b0;

  // ~ stands in for a zero byte, which a string literal cannot carry
  expr_row_t dir_rows[8] = '{
    '{" ",          1'b1, 32'sd0,  1'b0},  // no number at all
    '{"+7",         1'b1, 32'sd0,  1'b0},  // leading operator
    '{"1+-2",       1'b1, 32'sd0,  1'b0},  // doubled operator
    '{"3-",         1'b1, 32'sd0,  1'b0},  // trailing operator
    '{"1 2",        1'b1, 32'sd0,  1'b0},  // two numbers in a row
    '{"0-1",        1'b1, -32'sd1, 1'b1},
    '{"9\377-~9",   1'b0, 32'sd0,  1'b0},
    '{"4294967296", 1'b1, 32'sd0,  1'b1}   // wraps to zero
  };

  add_sub_expression_evaluator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function void clear_parser();
    sum_acc    = '0;
    num_acc    = '0;
    in_run     = 1'b0;
    num_seen   = 1'b0;
    sub_next   = 1'b0;
    bad_syntax = 1'b0;
  endfunction

  function void close_number();
    sum_acc  = sub_next ? sum_acc - num_acc : sum_acc + num_acc;
    num_acc  = '0;
    in_run   = 1'b0;
    num_seen = 1'b1;
  endfunction

  // returns 1 when the byte ends an expression, with the sum in r
  function bit parse_char(input ases_in_t b, output ases_out_t r);
    logic [31:0] dig;
    r   = '0;
    dig = 32'(b.ch - CH_ZERO);
    if (b.ch >= CH_ZERO && b.ch <= CH_NINE) begin
      if (!in_run) begin
        if (num_seen) bad_syntax = 1'b1;
        in_run  = 1'b1;
        num_acc = dig;
      end else begin
        num_acc = num_acc * TEN + dig;
      end
    end else begin
      if (in_run) close_number();
      if (b.ch == CH_PLUS || b.ch == CH_MINUS) begin
        if (!num_seen) bad_syntax = 1'b1;
        sub_next = (b.ch == CH_MINUS);
        num_seen = 1'b0;
      end
    end
    if (!b.last) return 1'b0;
    if (in_run) close_number();
    r.ok    = !bad_syntax && num_seen;
    r.value = r.ok ? sum_acc : '0;
    clear_parser();
    return 1'b1;
  endfunction

  function void put_ch(input logic [7:0] c);
    ases_in_t b;
    b.ch   = c;
    b.last = 1'b0;
    pend_bytes.push_back(b);
  endfunction

  function automatic logic [7:0] skip_byte();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return 8'h20;
    do
      c = 8'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS);
    return c;
  endfunction

  function automatic void put_gap(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) put_ch(skip_byte());
  endfunction

  function automatic void put_op();
    put_ch($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
  endfunction

  // mostly short numbers, now and then long enough to wrap
  function automatic void put_number();
    int nd;
    nd = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
    repeat (nd) put_ch(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void put_pairs(input int n);
    repeat (n) begin
      put_gap(0, 1);
      put_op();
      put_gap(0, 1);
      put_number();
    end
  endfunction

  function automatic void make_expr();
    int kind;
    int idx;
    pend_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      put_gap(0, 1);
      put_number();
      put_pairs($urandom_range(0, 6));
      put_gap(0, 2);
    end else if (kind < 88) begin
      case ($urandom_range(0, 4))
        0: begin
          put_op();
          put_number();
          put_pairs($urandom_range(0, 3));
        end
        1: begin
          put_number();
          put_op();
          put_gap(0, 1);
          put_op();
          put_number();
        end
        2: begin
          put_number();
          put_pairs($urandom_range(0, 3));
          put_gap(0, 1);
          put_op();
          put_gap(0, 1);
        end
        3: begin
          put_number();
          put_gap(1, 2);
          put_number();
          put_pairs($urandom_range(0, 2));
        end
        default: begin
          put_gap(1, 3);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 16)) put_ch(8'($urandom_range(0, 255)));
    end
    idx = pend_bytes.size() - 1;
    pend_bytes[idx].last = 1'b1;
  endfunction

  task flag_mismatch(input string msg);
    mism_cnt++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // drives one byte, holds it until accepted, then may idle for a burst
  task automatic send_byte(input ases_in_t b, input bit typed, input ases_out_t want);
    ases_out_t r;
    in_valid <= 1'b1;
    in_data  <= b;
    do
      @(posedge clk);
    while (!in_ready);
    sent_cnt++;
    if (parse_char(b, r)) sum_q.push_back(typed ? want : r);
    if (sent_cnt >= ITEMS_TOTAL - QUIET_TAIL) quiet = 1'b1;
    if (!quiet && tx_gappy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  initial begin
    ases_in_t   b;
    ases_out_t  want;
    logic [7:0] c;
    int         len;
    clear_parser();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      want.value = dir_rows[k].value;
      want.ok    = dir_rows[k].ok;
      len        = dir_rows[k].text.len();
      for (int i = 0; i < len; i++) begin
        c = dir_rows[k].text[i];
        if (c == "~") c = 8'h00;
        b.ch   = c;
        b.last = (i == len - 1);
        send_byte(b, dir_rows[k].typed, want);
      end
    end

    want = '0;
    while (sent_cnt < ITEMS_TOTAL) begin
      make_expr();
      tx_gappy = ($urandom_range(0, 3) != 0);
      foreach (pend_bytes[i]) send_byte(pend_bytes[i], 1'b0, want);
    end
    in_valid <= 1'b0;

    while (sum_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mism_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side: check each transaction, stall in random bursts
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (sum_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result value=%0d ok=%0b",
                                out_data.value, out_data.ok));
      end else begin
        head_sum = sum_q.pop_front();
        if (out_data.value !== head_sum.value)
          flag_mismatch($sformatf("value %0d, expected %0d",
                                  out_data.value, head_sum.value));
        if (out_data.ok !== head_sum.ok)
          flag_mismatch($sformatf("ok %0b, expected %0b", out_data.ok, head_sum.ok));
      end
    end

    rx_cycles++;
    if (rx_cycles % 200 == 0) rx_calm = ($urandom_range(0, 2) == 0);
    if (quiet || rx_calm) begin
      out_ready <= 1'b1;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_hold = $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
